// ----- rtl/bspc_pkg.sv -----
// Bounded-step path counter: shared types, constants and the microcode table.
// Depends on nothing; imported by bounded_step_path_counter.
`default_nettype none

package bspc_pkg;

    localparam int STAIRS_W = 20;
    localparam int WAYS_W   = 30;
    localparam int CFG_W    = 8;

    localparam logic [31:0] PRIME = 32'd1000000007;

    // Micro-program addresses
    typedef enum logic [2:0] {
        UPC_IDLE    = 3'd0,
        UPC_INIT    = 3'd1,
        UPC_ADVANCE = 3'd2,
        UPC_UPDATE  = 3'd3,
        UPC_DONE    = 3'd4
    } t_upc;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_NEVER    = 3'd0,
        COND_ALWAYS   = 3'd1,
        COND_NO_START = 3'd2,
        COND_ZERO_N   = 3'd3,
        COND_MORE     = 3'd4
    } t_cond;

    typedef struct packed {
        logic  busy;
        logic  init;
        logic  advance;
        logic  update;
        logic  emit;
        t_cond cond;
        t_upc  target;
    } t_uword;

    function automatic t_uword ucode_rom(input t_upc pc);
        t_uword w;
        w = '{busy: 1'b1, init: 1'b0, advance: 1'b0, update: 1'b0, emit: 1'b0,
              cond: COND_ALWAYS, target: UPC_IDLE};
        case (pc)
            UPC_IDLE: begin
                w.busy   = 1'b0;
                w.cond   = COND_NO_START;
                w.target = UPC_IDLE;
            end
            UPC_INIT: begin
                w.init   = 1'b1;
                w.cond   = COND_ZERO_N;
                w.target = UPC_DONE;
            end
            UPC_ADVANCE: begin
                w.advance = 1'b1;
                w.cond    = COND_NEVER;
                w.target  = UPC_IDLE;
            end
            UPC_UPDATE: begin
                w.update = 1'b1;
                w.cond   = COND_MORE;
                w.target = UPC_ADVANCE;
            end
            UPC_DONE: begin
                w.emit   = 1'b1;
                w.cond   = COND_ALWAYS;
                w.target = UPC_IDLE;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = UPC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bounded_step_path_counter.sv -----
// Bounded-step path counter: ways to climb n stairs with moves of 1..k, mod 1e9+7.
// One transaction at a time: the next start is taken in the strobe cycle. Each
// stair costs one read step and one update step of the ring RAM.
// Reset (synchronous, active low): sequencer idle, no strobe, max_step = 1.
// Results cannot be stalled by the receiver.
`default_nettype none

module bounded_step_path_counter #(
    parameter int MAX_STEP_LIMIT = 128,
    parameter int STAIR_BITS     = 20
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  [bspc_pkg::STAIRS_W-1:0]    i_stairs,
    output logic                             o_valid,
    output logic [bspc_pkg::WAYS_W-1:0]      o_ways,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [bspc_pkg::CFG_W-1:0]       i_cfg_data
);
    import bspc_pkg::*;

    localparam int NB = (STAIR_BITS < STAIRS_W) ? STAIR_BITS : STAIRS_W;
    localparam int SW = (MAX_STEP_LIMIT > 1) ? $clog2(MAX_STEP_LIMIT) : 1;
    localparam int KW = $clog2(MAX_STEP_LIMIT + 1);
    localparam int CW = (KW > CFG_W) ? KW : CFG_W;

    t_upc              r_pc, n_pc;
    t_uword            uw;
    logic              jump;

    logic [CFG_W-1:0]  r_max_step;
    logic [KW-1:0]     r_k;
    logic [NB-1:0]     r_n;
    logic [NB-1:0]     r_idx;
    logic [SW-1:0]     r_slot, n_slot;
    logic [WAYS_W-1:0] r_ws, n_ws;
    logic [WAYS_W-1:0] r_newest;
    logic [WAYS_W-1:0] r_rdata;
    logic [WAYS_W-1:0] leaving;
    logic [WAYS_W-1:0] mem [MAX_STEP_LIMIT];

    logic [CW-1:0]     cfg_ext, eff_k;
    logic [KW:0]       slot_inc;
    logic signed [31:0] diff;

    // Sequencer
    assign uw = ucode_rom(r_pc);

    always_comb begin
        case (uw.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_START: jump = !start;
            COND_ZERO_N:   jump = (r_n == '0);
            COND_MORE:     jump = (r_idx != r_n);
            default:       jump = 1'b1;
        endcase
    end

    always_comb begin
        if (jump) begin
            n_pc = uw.target;
        end else begin
            n_pc = t_upc'(r_pc + 3'd1);
        end
    end

    always_comb begin
        busy        = uw.busy;
        o_cfg_ready = !uw.busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= UPC_IDLE;
            r_max_step <= CFG_W'(1);
            o_valid    <= 1'b0;
        end else begin
            r_pc    <= n_pc;
            o_valid <= uw.emit;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_step <= i_cfg_data;
            end
        end
    end

    // Datapath
    always_comb begin
        cfg_ext = CW'(r_max_step);
        if (cfg_ext == '0) begin
            eff_k = CW'(1);
        end else if (cfg_ext > CW'(MAX_STEP_LIMIT)) begin
            eff_k = CW'(MAX_STEP_LIMIT);
        end else begin
            eff_k = cfg_ext;
        end
    end

    always_comb begin
        slot_inc = (KW + 1)'(r_slot) + (KW + 1)'(1);
        if (slot_inc >= (KW + 1)'(r_k)) begin
            n_slot = '0;
        end else begin
            n_slot = SW'(slot_inc);
        end
    end

    // Slots not yet written in this transaction read as zero
    assign leaving = (32'(r_idx) < 32'(r_k)) ? '0 : r_rdata;

    always_comb begin
        diff = $signed({1'b0, r_ws, 1'b0}) - $signed({2'b00, leaving});
        if (diff < 0) begin
            n_ws = WAYS_W'(diff + $signed(PRIME));
        end else if (diff >= $signed(PRIME)) begin
            n_ws = WAYS_W'(diff - $signed(PRIME));
        end else begin
            n_ws = WAYS_W'(diff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_n <= i_stairs[NB-1:0];
        end
        if (uw.init) begin
            r_k      <= KW'(eff_k);
            r_idx    <= '0;
            r_slot   <= '0;
            r_ws     <= WAYS_W'(1);
            r_newest <= WAYS_W'(1);
        end
        if (uw.advance) begin
            r_slot <= n_slot;
            r_idx  <= r_idx + NB'(1);
        end
        if (uw.update) begin
            r_ws     <= n_ws;
            r_newest <= r_ws;
        end
        if (uw.emit) begin
            o_ways <= r_newest;
        end
    end

    // Ring RAM
    always_ff @(posedge i_clk) begin
        if (uw.init) begin
            mem[0] <= WAYS_W'(1);
        end else if (uw.update) begin
            mem[r_slot] <= r_ws;
        end
        if (uw.advance) begin
            r_rdata <= mem[n_slot];
        end
    end

    // Assertions
    a_ways_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({2'b00, o_ways} < PRIME))
        else $error("result not reduced");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("strobe longer than one cycle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

endmodule

`default_nettype wire

// ----- test/tb_bounded_step_path_counter.sv -----
// Testbench for bounded_step_path_counter: step-limited stair counts modulo 1e9+7.
// A scoreboard class predicts each answer and checks it; plain tasks drive the ports.
// Depends on rtl/bspc_pkg.sv and rtl/bounded_step_path_counter.sv.
`timescale 1ns / 100ps

module tb_bounded_step_path_counter;
    import bspc_pkg::*;

    localparam int RING_DEPTH = 128;
    localparam int STALL_LIMIT = 6_500_000;
    localparam logic [STAIRS_W-1:0] MOST_STAIRS = '1;

    class ways_scoreboard;
        logic [WAYS_W-1:0] pending_ways[$];
        logic [CFG_W-1:0] max_step;
        int errors;

        function new();
            max_step = 1;
            errors = 0;
        endfunction

        function void set_max_step(input logic [CFG_W-1:0] value);
            max_step = value;
        endfunction

        function logic [WAYS_W-1:0] count_paths(input logic [STAIRS_W-1:0] stairs);
            logic [WAYS_W-1:0] ring[RING_DEPTH];
            longint unsigned window, newest, leaving;
            int unsigned step_limit, slot, i;
            step_limit = max_step;
            if (step_limit < 1) step_limit = 1;
            if (step_limit > RING_DEPTH) step_limit = RING_DEPTH;
            foreach (ring[j]) ring[j] = '0;
            ring[0] = 1;
            window = 1;
            newest = 1;
            slot = 0;
            for (i = 1; i <= stairs; i++) begin
                slot++;
                if (slot >= step_limit) slot = 0;
                newest = window;
                leaving = ring[slot];
                window = (window + newest + PRIME - leaving) % PRIME;
                ring[slot] = newest[WAYS_W-1:0];
            end
            return newest[WAYS_W-1:0];
        endfunction

        function void note_query(input logic [STAIRS_W-1:0] stairs);
            pending_ways.push_back(count_paths(stairs));
        endfunction

        function void check_ways(input logic [WAYS_W-1:0] actual);
            logic [WAYS_W-1:0] expected;
            if (pending_ways.size() == 0) begin
                $error("ways: no result expected, actual %0d", actual);
                errors++;
            end else begin
                expected = pending_ways.pop_front();
                if (actual !== expected) begin
                    $error("ways: expected %0d, actual %0d", expected, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return pending_ways.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [STAIRS_W-1:0] i_stairs = '0;
    logic o_valid;
    logic [WAYS_W-1:0] o_ways;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data = '0;

    ways_scoreboard sb = new();
    int stall_cycles = 0;

    bounded_step_path_counter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_stairs    (i_stairs),
        .o_valid     (o_valid),
        .o_ways      (o_ways),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_ways(o_ways);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[bounded_step_path_counter] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_query(input logic [STAIRS_W-1:0] stairs, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_stairs <= stairs;
        do @(posedge i_clk); while (busy);
        sb.note_query(stairs);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_max_step(input logic [CFG_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_max_step(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [STAIRS_W-1:0] random_stairs();
        if ($urandom_range(49) == 0) return STAIRS_W'($urandom_range(5000, 1000));
        return STAIRS_W'($urandom_range(300, 0));
    endfunction

    initial begin
        int idle_pcts[5];
        logic [CFG_W-1:0] steps[5];
        idle_pcts = '{0, 65, 30, 0, 65};
        steps[0] = CFG_W'($urandom_range(255, 0));
        steps[1] = RING_DEPTH;
        steps[2] = 1;
        steps[3] = CFG_W'($urandom_range(255, RING_DEPTH + 1));
        steps[4] = CFG_W'($urandom_range(16, 2));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset step limit of one
        send_query(0, 0);
        send_query(1, 0);
        send_query(7, 0);

        // zero limit behaves as one
        write_max_step(0);
        send_query(4, 0);

        // two-step: Fibonacci, wraps the modulus at 45
        write_max_step(2);
        send_query(0, 0);
        send_query(1, 0);
        send_query(2, 0);
        send_query(3, 0);
        send_query(10, 0);
        send_query(45, 0);

        // full ring; limit above the stair count too
        write_max_step(RING_DEPTH);
        send_query(1, 0);
        send_query(5, 0);
        send_query(127, 0);
        send_query(128, 0);
        send_query(129, 0);
        send_query(600, 0);

        // limit above the ring saturates; the one longest transaction
        write_max_step('1);
        send_query(130, 0);
        send_query(MOST_STAIRS, 0);

        for (int p = 0; p < 5; p++) begin
            write_max_step(steps[p]);
            for (int n = 0; n < 20; n++) begin
                if ($urandom_range(9) == 0) wait_drained();
                send_query(random_stairs(), idle_pcts[p]);
            end
        end

        wait_drained();
        repeat (50) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[bounded_step_path_counter] OK");
        end else begin
            $display("[bounded_step_path_counter] ERROR");
        end
        $finish;
    end

endmodule
